@@ hdl/ftfi_pkg.sv @@
`default_nettype none
package ftfi_pkg;

    localparam int SECTORS_PER_TRACK = 9;
    localparam int TRACK_BYTES       = 7168;

    localparam int POS_W   = 13;
    localparam int SLOT_W  = 4;
    localparam int OFF_W   = 10;
    localparam int ORDER_W = 36;
    localparam int NUM_ORDER_SLOTS = ORDER_W / 4;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 36'h594837261;

    localparam logic [POS_W-1:0] LEADER_LEN = 13'd256;
    localparam logic [OFF_W-1:0] BLOCK_LEN  = 10'd636;
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(TRACK_BYTES - 1);
    localparam logic [SLOT_W-1:0] NUM_SECTORS = SLOT_W'(SECTORS_PER_TRACK);

    localparam logic [7:0] GAP_BYTE   = 8'h4e;
    localparam logic [7:0] SYNC_BYTE  = 8'h00;
    localparam logic [7:0] C2_BYTE    = 8'hf6;
    localparam logic [7:0] IAM_BYTE   = 8'hfc;
    localparam logic [7:0] FILL_BYTE  = 8'hff;
    localparam logic [7:0] A1_BYTE    = 8'hf5;
    localparam logic [7:0] IDAM_BYTE  = 8'hfe;
    localparam logic [7:0] CRC_BYTE   = 8'hf7;
    localparam logic [7:0] DAM_BYTE   = 8'hfb;
    localparam logic [7:0] SIZE_CODE  = 8'h02;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  off;
    } t_pos;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       in_block;
    } t_sel;

endpackage
`default_nettype wire

@@ hdl/ftfi_byte_sel.sv @@
`default_nettype none
module ftfi_byte_sel
    import ftfi_pkg::*;
(
    input  wire t_pos               i_pos,
    input  wire logic [7:0]         i_cylinder,
    input  wire logic               i_head,
    input  wire logic [ORDER_W-1:0] i_order,
    output t_sel                    o_sel
);

    logic [7:0] leader_b;
    logic [7:0] block_b;
    logic [3:0] sector_num;

    always_comb begin
        sector_num = 4'd0;
        for (int i = 0; i < NUM_ORDER_SLOTS; i++) begin
            if (i_pos.slot == SLOT_W'(i)) begin
                sector_num = i_order[4*i +: 4];
            end
        end
    end

    always_comb begin
        if (i_pos.pos < 13'd160)       leader_b = GAP_BYTE;
        else if (i_pos.pos < 13'd172)  leader_b = SYNC_BYTE;
        else if (i_pos.pos < 13'd175)  leader_b = C2_BYTE;
        else if (i_pos.pos == 13'd175) leader_b = IAM_BYTE;
        else                           leader_b = FILL_BYTE;
    end

    always_comb begin
        if (i_pos.off < 10'd12)        block_b = SYNC_BYTE;
        else if (i_pos.off < 10'd15)   block_b = A1_BYTE;
        else if (i_pos.off == 10'd15)  block_b = IDAM_BYTE;
        else if (i_pos.off == 10'd16)  block_b = i_cylinder;
        else if (i_pos.off == 10'd17)  block_b = {7'd0, i_head};
        else if (i_pos.off == 10'd18)  block_b = {4'd0, sector_num};
        else if (i_pos.off == 10'd19)  block_b = SIZE_CODE;
        else if (i_pos.off == 10'd20)  block_b = CRC_BYTE;
        else if (i_pos.off < 10'd43)   block_b = GAP_BYTE;
        else if (i_pos.off < 10'd55)   block_b = SYNC_BYTE;
        else if (i_pos.off < 10'd58)   block_b = A1_BYTE;
        else if (i_pos.off == 10'd58)  block_b = DAM_BYTE;
        else if (i_pos.off < 10'd571)  block_b = SYNC_BYTE;
        else if (i_pos.off == 10'd571) block_b = CRC_BYTE;
        else                           block_b = GAP_BYTE;
    end

    always_comb begin
        o_sel.in_block = 1'b0;
        if (i_pos.pos < LEADER_LEN) begin
            o_sel.data = leader_b;
        end else if (i_pos.slot < NUM_SECTORS) begin
            o_sel.data     = block_b;
            o_sel.in_block = 1'b1;
        end else begin
            o_sel.data = GAP_BYTE;
        end
        o_sel.last = (i_pos.pos >= LAST_POS);
    end

endmodule
`default_nettype wire

@@ hdl/floppy_track_format_image_generator_unit.sv @@
`default_nettype none
// channel   dir   handshake                    payload
// s_axis    in    s_axis_tvalid/s_axis_tready  tdata: cylinder, head; tuser: track_start
// m_axis    out   m_axis_tvalid/m_axis_tready  tdata: track_byte; tlast: last_byte
// cfg       in    i_cfg_valid/o_cfg_ready      i_cfg_data: sector_order
//
// one word in, one track byte out; a new word is taken every cycle while m_axis does not stall.
// each word passes the input register, then byte select into the output register.
// the output register frees itself in the cycle it is taken, so stalls on
// m_axis only back up into s_axis when both registers are full.
// synchronous active-low reset clears the position counters and loads the
// default interleave order.
module floppy_track_format_image_generator_unit
    import ftfi_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [15:0]        s_axis_tdata,   // [7:0] cylinder, [8] head
    input  wire logic               s_axis_tuser,   // [0] track_start
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [7:0] track_byte
    output logic                    m_axis_tlast,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [ORDER_W-1:0] i_cfg_data
);

    logic [ORDER_W-1:0] r_order;
    logic               r_in_valid;
    logic [7:0]         r_cyl;
    logic               r_head;
    logic               r_start;
    t_pos               r_pos;
    t_pos               n_pos;
    t_pos               cur_pos;
    t_sel               sel;
    logic               r_out_valid;
    logic [7:0]         r_out_data;
    logic               r_out_last;
    logic               out_free;
    logic               advance;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // track_start restarts before the byte is chosen
    always_comb begin
        if (r_start) cur_pos = '0;
        else         cur_pos = r_pos;
    end

    ftfi_byte_sel u_sel (
        .i_pos      (cur_pos),
        .i_cylinder (r_cyl),
        .i_head     (r_head),
        .i_order    (r_order),
        .o_sel      (sel)
    );

    always_comb begin
        n_pos = cur_pos;
        if (sel.last) begin
            n_pos = '0;
        end else begin
            n_pos.pos = cur_pos.pos + 1'b1;
            if (sel.in_block) begin
                if (cur_pos.off == BLOCK_LEN - 1'b1) begin
                    n_pos.off  = '0;
                    n_pos.slot = cur_pos.slot + 1'b1;
                end else begin
                    n_pos.off = cur_pos.off + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order     <= ORDER_RESET;
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_order <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_pos <= n_pos;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_cyl   <= s_axis_tdata[7:0];
            r_head  <= s_axis_tdata[8];
            r_start <= s_axis_tuser;
        end
        if (advance) begin
            r_out_data <= sel.data;
            r_out_last <= sel.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ftfi_pkg::*;

    localparam logic [35:0] DEFAULT_ORDER = 36'h594837261;
    localparam int          TRACK_LEN     = 7168;
    localparam int          LEADER_BYTES  = 256;
    localparam int          SECTOR_BYTES  = 636;
    localparam int          SECTOR_COUNT  = 9;
    localparam logic [7:0]  B_GAP  = 8'h4e;
    localparam logic [7:0]  B_SYNC = 8'h00;
    localparam logic [7:0]  B_C2   = 8'hf6;
    localparam logic [7:0]  B_IAM  = 8'hfc;
    localparam logic [7:0]  B_FILL = 8'hff;
    localparam logic [7:0]  B_A1   = 8'hf5;
    localparam logic [7:0]  B_IDAM = 8'hfe;
    localparam logic [7:0]  B_CRC  = 8'hf7;
    localparam logic [7:0]  B_DAM  = 8'hfb;
    localparam logic [7:0]  B_SIZE = 8'h02;

    typedef struct packed {
        logic [7:0] cyl;
        logic       head;
        logic       start;
    } format_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } track_byte_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;
    logic               m_axis_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [ORDER_W-1:0] cfg_data = '0;

    format_req_t pending_words[$];
    track_byte_t track_bytes_due[$];

    // shadow of the track position counters and interleave register
    logic [12:0] trk_pos   = '0;
    logic [3:0]  trk_slot  = '0;
    logic [9:0]  trk_off   = '0;
    logic [35:0] order_now = DEFAULT_ORDER;

    logic word_taken = 1'b0;
    logic calm = 1'b0;
    logic rx_stall = 1'b0;
    int   words_sent = 0;
    int   mismatches = 0;

    floppy_track_format_image_generator_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [7:0] leader_byte(input logic [12:0] p);
        if (p < 160) return B_GAP;
        if (p < 172) return B_SYNC;
        if (p < 175) return B_C2;
        if (p == 175) return B_IAM;
        return B_FILL;
    endfunction

    function automatic logic [7:0] sector_byte(input logic [9:0] off, input logic [7:0] cyl,
                                               input logic head, input logic [3:0] slot);
        if (off < 12) return B_SYNC;
        if (off < 15) return B_A1;
        if (off == 15) return B_IDAM;
        if (off == 16) return cyl;
        if (off == 17) return {7'd0, head};
        if (off == 18) begin
            // only nine slots live in the register
            if (slot >= 9) return 8'h00;
            return {4'd0, order_now[4*slot +: 4]};
        end
        if (off == 19) return B_SIZE;
        if (off == 20) return B_CRC;
        if (off < 43) return B_GAP;
        if (off < 55) return B_SYNC;
        if (off < 58) return B_A1;
        if (off == 58) return B_DAM;
        if (off < 571) return B_SYNC;
        if (off == 571) return B_CRC;
        return B_GAP;
    endfunction

    task automatic predict_track_byte(input format_req_t w);
        track_byte_t nb;
        logic        in_sector;
        in_sector = 1'b0;
        if (w.start) begin
            trk_pos  = '0;
            trk_slot = '0;
            trk_off  = '0;
        end
        if (trk_pos < LEADER_BYTES) begin
            nb.data = leader_byte(trk_pos);
        end else if (trk_slot < SECTOR_COUNT) begin
            in_sector = 1'b1;
            nb.data = sector_byte(trk_off, w.cyl, w.head, trk_slot);
        end else begin
            nb.data = B_GAP;
        end
        nb.last = (trk_pos >= TRACK_LEN - 1);
        track_bytes_due.push_back(nb);
        if (nb.last) begin
            trk_pos  = '0;
            trk_slot = '0;
            trk_off  = '0;
        end else begin
            trk_pos = trk_pos + 13'd1;
            if (in_sector) begin
                trk_off = trk_off + 10'd1;
                if (trk_off >= SECTOR_BYTES) begin
                    trk_off  = '0;
                    trk_slot = trk_slot + 4'd1;
                end
            end
        end
    endtask

    // sender: accept seen at the rising edge, next word set up at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_track_byte(pending_words[0]);
            void'(pending_words.pop_front());
            words_sent++;
            word_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!s_axis_tvalid || word_taken) begin
            if (i_rst_n && pending_words.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, pending_words[0].head, pending_words[0].cyl};
                s_axis_tuser  <= pending_words[0].start;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        word_taken = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !rx_stall && (calm || $urandom_range(99) >= 8);
    end

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (mismatches < 10)
            $display("%0t: %s mismatch, expected %02h got %02h", $realtime, what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        track_byte_t due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (track_bytes_due.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected byte %02h", $realtime, m_axis_tdata);
                mismatches++;
            end else begin
                due = track_bytes_due.pop_front();
                if (m_axis_tdata !== due.data)
                    note_mismatch("track_byte", due.data, m_axis_tdata);
                if (m_axis_tlast !== due.last)
                    note_mismatch("last_byte", {7'd0, due.last}, {7'd0, m_axis_tlast});
            end
        end
    end

    // long receiver hold-off while the sender keeps offering words
    initial begin
        wait (words_sent >= 100);
        @(posedge i_clk);
        rx_stall = 1'b1;
        repeat (400) @(posedge i_clk);
        rx_stall = 1'b0;
    end

    initial begin
        #(2_000_000);
        $display("status: fail");
        $finish;
    end

    task automatic push_word(input logic [7:0] cyl, input logic head, input logic start);
        format_req_t w;
        w.cyl   = cyl;
        w.head  = head;
        w.start = start;
        pending_words.push_back(w);
    endtask

    function automatic logic [7:0] pick_cylinder();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // consecutive bytes of one track; restart only on the first word
    task automatic push_track_run(input int n);
        for (int i = 0; i < n; i++)
            push_word(pick_cylinder(), 1'($urandom), i == 0);
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++)
            push_word(8'($urandom), 1'($urandom), $urandom_range(99) < 3);
    endtask

    task automatic drain_all();
        while (pending_words.size() != 0 || track_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sector_order(input logic [35:0] order);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= order;
        do @(posedge i_clk); while (!cfg_ready);
        order_now = order;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // restarts at the head of the track, field extremes
        push_word(8'hff, 1'b1, 1'b1);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'ha5, 1'b1, 1'b0);
        push_word(8'h5a, 1'b0, 1'b1);
        push_word(8'h80, 1'b1, 1'b1);
        push_word(8'h01, 1'b0, 1'b0);
        push_word(8'h7f, 1'b1, 1'b0);
        push_word(8'h00, 1'b1, 1'b1);
        drain_all();

        // leader and first sector id field with the default interleave
        push_track_run(280);
        drain_all();

        write_sector_order(36'({$urandom, $urandom}));
        // no idling, random restarts
        calm = 1'b1;
        push_noise(115);
        drain_all();
        calm = 1'b0;

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && track_bytes_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
hdl/ftfi_pkg.sv
hdl/ftfi_byte_sel.sv
hdl/floppy_track_format_image_generator_unit.sv
test/tb.sv
